FILE: src/tswc_pkg.sv
`default_nettype none

package tswc_pkg;

    localparam int VALUE_W     = 11;
    localparam int TARGET_W    = 12;
    localparam int WAYS_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // one number as handed from the front to the back
    typedef struct packed {
        logic [VALUE_W-1:0]         value;
        logic signed [TARGET_W-1:0] target;
        logic                       last;
        logic                       range_err;  // running sum left the table here
    } t_job;

endpackage

`default_nettype wire

FILE: src/target_sum_way_counter.sv
`default_nettype none

// Counts the ways to sign a set of numbers (+n or -n each) so their sum hits a target.
// Send one number per item; the item with tlast high closes the set and carries the
// target, and only that item produces a result: the count (saturating at 32 bits) and a
// status of 0 ok, 1 count saturated, 2 running sum went past MAX_SUM. Each number is
// handled by one sweep over the signed-sum count table, one entry per cycle, reading one
// bank of two-read-port memory and writing the other. A two-entry queue in front
// takes new items while a sweep runs or a result waits. No clearing pass is needed after
// reset or between sets.
module target_sum_way_counter #(
    parameter int MAX_SUM     = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [tswc_pkg::S_TDATA_W-1:0]   i_s_axis_tdata, // value[10:0], target[22:11]
    input  wire logic                             i_s_axis_tlast, // last
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [tswc_pkg::M_TDATA_W-1:0]        o_m_axis_tdata  // ways[31:0], status[33:32]
);

    logic           push;
    logic           full;
    logic           pop;
    logic           job_valid;
    tswc_pkg::t_job in_job;
    tswc_pkg::t_job out_job;

    tswc_front #(.MAX_SUM(MAX_SUM)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_full          (full),
        .o_push          (push),
        .o_job           (in_job)
    );

    tswc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (in_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (out_job)
    );

    tswc_back #(.MAX_SUM(MAX_SUM), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (out_job),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: src/tswc_ram.sv
`default_nettype none

module tswc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2049
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

FILE: src/tswc_front.sv
`default_nettype none

module tswc_front #(
    parameter int MAX_SUM = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [tswc_pkg::S_TDATA_W-1:0]   i_s_axis_tdata, // value, target, pad
    input  wire logic                             i_s_axis_tlast,  // last
    input  wire logic                             i_full,
    output logic                                  o_push,
    output tswc_pkg::t_job                        o_job
);

    localparam int RW = $clog2(MAX_SUM + 1);
    localparam int SW = (RW > tswc_pkg::VALUE_W ? RW : tswc_pkg::VALUE_W) + 1;

    logic [RW-1:0] r_reach;
    logic [RW-1:0] n_reach;
    logic [tswc_pkg::VALUE_W-1:0] value;
    logic                         over;

    assign value = i_s_axis_tdata[tswc_pkg::VALUE_W-1:0];
    assign over  = SW'(value) > (SW'(MAX_SUM) - SW'(r_reach));

    assign o_s_axis_tready = !i_full;
    assign o_push          = i_s_axis_tvalid && !i_full;

    always_comb begin
        o_job.value     = value;
        o_job.target    = i_s_axis_tdata[tswc_pkg::VALUE_W +: tswc_pkg::TARGET_W];
        o_job.last      = i_s_axis_tlast;
        o_job.range_err = over;
    end

    always_comb begin
        if (i_s_axis_tlast) begin
            n_reach = '0;
        end else if (over) begin
            n_reach = RW'(MAX_SUM);
        end else begin
            n_reach = RW'(SW'(r_reach) + SW'(value));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach <= '0;
        end else if (o_push) begin
            r_reach <= n_reach;
        end
    end

endmodule

`default_nettype wire

FILE: src/tswc_queue.sv
`default_nettype none

module tswc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tswc_pkg::t_job  i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output tswc_pkg::t_job       o_job
);

    tswc_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

FILE: src/tswc_back.sv
`default_nettype none

module tswc_back #(
    parameter int MAX_SUM     = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_job_valid,
    input  wire tswc_pkg::t_job                   i_job,
    output logic                                  o_pop,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [tswc_pkg::M_TDATA_W-1:0]        o_m_axis_tdata // ways, status, pad
);

    localparam int DEPTH = 2 * MAX_SUM + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = (AW > tswc_pkg::VALUE_W ? AW : tswc_pkg::VALUE_W) + 1;
    localparam int TW    = (AW > tswc_pkg::TARGET_W ? AW : tswc_pkg::TARGET_W) + 2;
    localparam int OW    = COUNT_WIDTH > tswc_pkg::WAYS_W ? COUNT_WIDTH : tswc_pkg::WAYS_W;
    localparam int PADW  = tswc_pkg::M_TDATA_W - tswc_pkg::WAYS_W - tswc_pkg::STATUS_W;
    localparam logic [AW-1:0]        LAST_IDX = AW'(DEPTH - 1);
    localparam logic signed [TW-1:0] T_OFS    = TW'(MAX_SUM);
    localparam logic signed [TW-1:0] T_DEPTH  = TW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_END
    } t_state;

    t_state                   r_state;
    tswc_pkg::t_job           r_job;
    logic [AW-1:0]            r_tidx;
    logic                     r_tok;
    logic [AW-1:0]            r_i;
    logic                     r_pend;
    logic [AW-1:0]            r_wi;
    logic                     r_lo_ok;
    logic                     r_hi_ok;
    logic                     r_lo_one;
    logic                     r_hi_one;
    logic                     r_bank;   // 0: bank a holds the current table
    logic                     r_fresh;  // current table is the one-at-zero start
    logic                     r_sat;
    logic                     r_rng;
    logic [COUNT_WIDTH-1:0]   r_ways;
    logic                     r_ovalid;
    logic [tswc_pkg::WAYS_W-1:0]   r_oways;
    logic [tswc_pkg::STATUS_W-1:0] r_ostatus;

    logic [XW-1:0]            x_i;
    logic [XW-1:0]            x_v;
    logic [XW-1:0]            lo_full;
    logic [XW-1:0]            hi_full;
    logic                     lo_ok;
    logic                     hi_ok;
    logic [AW-1:0]            lo_addr;
    logic [AW-1:0]            hi_addr;
    logic signed [TW-1:0]     tidx_full;
    logic [COUNT_WIDTH-1:0]   q_a_lo;
    logic [COUNT_WIDTH-1:0]   q_a_hi;
    logic [COUNT_WIDTH-1:0]   q_b_lo;
    logic [COUNT_WIDTH-1:0]   q_b_hi;
    logic [COUNT_WIDTH-1:0]   lo_val;
    logic [COUNT_WIDTH-1:0]   hi_val;
    logic [COUNT_WIDTH:0]     sum;
    logic                     sat_now;
    logic [COUNT_WIDTH-1:0]   wdata;
    logic                     we_a;
    logic                     we_b;
    logic [OW-1:0]            ways_ext;
    logic                     ways_big;
    logic                     out_free;

    // read side: old[i-v] and old[i+v]
    assign x_i     = XW'(r_i);
    assign x_v     = XW'(r_job.value);
    assign lo_full = x_i - x_v;
    assign hi_full = x_i + x_v;
    assign lo_ok   = x_i >= x_v;
    assign hi_ok   = hi_full < XW'(DEPTH);
    assign lo_addr = lo_ok ? lo_full[AW-1:0] : '0;
    assign hi_addr = hi_ok ? hi_full[AW-1:0] : '0;

    assign tidx_full = TW'(i_job.target) + T_OFS;

    tswc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_bank_a (
        .i_clk     (i_clk),
        .i_we      (we_a),
        .i_waddr   (r_wi),
        .i_wdata   (wdata),
        .i_raddr_a (lo_addr),
        .i_raddr_b (hi_addr),
        .o_rdata_a (q_a_lo),
        .o_rdata_b (q_a_hi)
    );

    tswc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_bank_b (
        .i_clk     (i_clk),
        .i_we      (we_b),
        .i_waddr   (r_wi),
        .i_wdata   (wdata),
        .i_raddr_a (lo_addr),
        .i_raddr_b (hi_addr),
        .o_rdata_a (q_b_lo),
        .o_rdata_b (q_b_hi)
    );

    // write side: one saturating add per entry
    always_comb begin
        if (r_fresh) begin
            lo_val = COUNT_WIDTH'(r_lo_one);
            hi_val = COUNT_WIDTH'(r_hi_one);
        end else begin
            lo_val = r_lo_ok ? (r_bank ? q_b_lo : q_a_lo) : '0;
            hi_val = r_hi_ok ? (r_bank ? q_b_hi : q_a_hi) : '0;
        end
    end

    assign sum     = {1'b0, lo_val} + {1'b0, hi_val};
    assign sat_now = sum[COUNT_WIDTH];
    assign wdata   = sat_now ? '1 : sum[COUNT_WIDTH-1:0];
    assign we_a    = r_pend && r_bank;
    assign we_b    = r_pend && !r_bank;

    assign ways_ext = OW'(r_ways);
    assign ways_big = |(ways_ext >> tswc_pkg::WAYS_W);
    assign out_free = !r_ovalid || i_m_axis_tready;

    assign o_pop = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_bank   <= 1'b0;
            r_fresh  <= 1'b1;
            r_sat    <= 1'b0;
            r_rng    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // a new result loaded in S_END takes the place of the one leaving
            if (r_ovalid && i_m_axis_tready && !(r_state == S_END && r_job.last)) begin
                r_ovalid <= 1'b0;
            end
            r_pend   <= r_state == S_SWEEP;
            r_wi     <= r_i;
            r_lo_ok  <= lo_ok;
            r_hi_ok  <= hi_ok;
            r_lo_one <= lo_ok && (lo_full == XW'(MAX_SUM));
            r_hi_one <= hi_ok && (hi_full == XW'(MAX_SUM));
            if (r_pend) begin
                r_sat <= r_sat | sat_now;
                if (r_tok && r_wi == r_tidx) begin
                    r_ways <= wdata;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_tidx  <= tidx_full[AW-1:0];
                        r_tok   <= !tidx_full[TW-1] && (tidx_full < T_DEPTH);
                        r_ways  <= '0;
                        r_rng   <= r_rng | i_job.range_err;
                        r_i     <= '0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_i == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_END;
                end
                S_END: begin
                    if (!r_job.last) begin
                        r_bank  <= !r_bank;
                        r_fresh <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_oways   <= ways_big ? '1 : ways_ext[tswc_pkg::WAYS_W-1:0];
                        if (r_rng) begin
                            r_ostatus <= tswc_pkg::ST_RANGE;
                        end else if (r_sat || ways_big) begin
                            r_ostatus <= tswc_pkg::ST_SAT;
                        end else begin
                            r_ostatus <= tswc_pkg::ST_OK;
                        end
                        r_bank  <= !r_bank;
                        r_fresh <= 1'b1;
                        r_sat   <= 1'b0;
                        r_rng   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{PADW{1'b0}}, r_ostatus, r_oways};

`ifndef SYNTHESIS
    a_result_only_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_END && r_job.last))
        else $error("result raised outside end of a last item");

    a_pop_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_SWEEP && r_i == '0))
        else $error("popped item did not start a sweep at entry zero");

    a_sweep_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_i <= LAST_IDX))
        else $error("sweep index beyond table");

    a_drain_writes_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_pend && r_wi == LAST_IDX))
        else $error("drain cycle without the final table write");
`endif

endmodule

`default_nettype wire
